>>> rtl/permutation_order_core_assert.svh
// Assertion macros for the permutation order core.
// Needs clk and rst in the scope where a macro is used.
`ifndef PERMUTATION_ORDER_CORE_ASSERT_SVH
`define PERMUTATION_ORDER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PO_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/po_pkg.sv
// Shared types and constants for the permutation order core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package po_pkg;

  localparam int IMG_W  = 10;
  localparam int ORD_W  = 64;
  localparam int STAT_W = 2;
  localparam int OP_W   = 5;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_VALID = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUP   = 2'd2;

  // Datapath operations issued by the controller
  localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
  localparam logic [OP_W-1:0] OP_CLR      = 5'd2;
  localparam logic [OP_W-1:0] OP_OVR      = 5'd3;
  localparam logic [OP_W-1:0] OP_CHK_MK   = 5'd4;
  localparam logic [OP_W-1:0] OP_CHK_TST  = 5'd5;
  localparam logic [OP_W-1:0] OP_WLK_TST  = 5'd6;
  localparam logic [OP_W-1:0] OP_NEXT     = 5'd7;
  localparam logic [OP_W-1:0] OP_STEP     = 5'd8;
  localparam logic [OP_W-1:0] OP_UPD      = 5'd9;
  localparam logic [OP_W-1:0] OP_DIV1     = 5'd10;
  localparam logic [OP_W-1:0] OP_GCD_INIT = 5'd11;
  localparam logic [OP_W-1:0] OP_GCD      = 5'd12;
  localparam logic [OP_W-1:0] OP_DIV2     = 5'd13;
  localparam logic [OP_W-1:0] OP_MUL      = 5'd14;
  localparam logic [OP_W-1:0] OP_MUL_CHK  = 5'd15;
  localparam logic [OP_W-1:0] OP_OUT      = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;   // sweep covers the whole mark memory
  } cmd_t;

  typedef struct packed {
    logic ovr;        // more entries than the memory holds
    logic bad;        // current check entry is out of range or a duplicate
    logic last;       // pointer is at the last loaded entry
    logic clr_last;   // pointer is at the end of the clear sweep
    logic new_cycle;  // walk start point opens an unvisited cycle
    logic step_go;    // cycle walk has not closed yet
    logic div_done;   // divider result ready
    logic gcd_done;   // gcd settled
    logic ovf;        // order saturated
    logic err_any;    // check found a fault
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/po_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on po_pkg for the dividend width.
`timescale 1ns / 1ps
`default_nettype none
module po_div
  import po_pkg::*;
#(
  parameter int DW = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [ORD_W-1:0] dividend,
  input  wire logic [DW-1:0]    divisor,
  output logic [ORD_W-1:0]      quo,
  output logic [DW-1:0]         rem,
  output logic                  done
);

  localparam int CNT_W = $clog2(ORD_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    dsr;
  logic [DW:0]      sh;
  logic [DW:0]      diff;

  // Shift in the next dividend bit and try the subtraction
  assign sh   = {rem, quo[ORD_W-1]};
  assign diff = sh - {1'b0, dsr};

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (start) begin
        cnt <= CNT_W'(ORD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // Quotient and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (cnt != '0) begin
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
        quo <= {quo[ORD_W-2:0], 1'b1};
      end else begin
        rem <= sh[DW-1:0];
        quo <= {quo[ORD_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/po_ctrl.sv
// Controller state machine: load, check, clear, cycle walk, lcm fold, result.
// Depends on po_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module po_ctrl
  import po_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic last_entry,
  input  wire sts_t st,
  output cmd_t      cmd,
  output logic      busy,
  output logic      done
);

  localparam logic [4:0] S_CLR0      = 5'd0;
  localparam logic [4:0] S_LOAD      = 5'd1;
  localparam logic [4:0] S_CHK_PRE   = 5'd2;
  localparam logic [4:0] S_CHK_RD    = 5'd3;
  localparam logic [4:0] S_CHK_MK    = 5'd4;
  localparam logic [4:0] S_CHK_TST   = 5'd5;
  localparam logic [4:0] S_CLR1      = 5'd6;
  localparam logic [4:0] S_WLK_RD    = 5'd7;
  localparam logic [4:0] S_WLK_TST   = 5'd8;
  localparam logic [4:0] S_NEXT      = 5'd9;
  localparam logic [4:0] S_STEP_CHK  = 5'd10;
  localparam logic [4:0] S_STEP_RD   = 5'd11;
  localparam logic [4:0] S_STEP_UPD  = 5'd12;
  localparam logic [4:0] S_DIV1_GO   = 5'd13;
  localparam logic [4:0] S_DIV1_WAIT = 5'd14;
  localparam logic [4:0] S_GCD       = 5'd15;
  localparam logic [4:0] S_DIV2_GO   = 5'd16;
  localparam logic [4:0] S_DIV2_WAIT = 5'd17;
  localparam logic [4:0] S_MUL       = 5'd18;
  localparam logic [4:0] S_MUL_CHK   = 5'd19;
  localparam logic [4:0] S_CLR2      = 5'd20;
  localparam logic [4:0] S_OUT       = 5'd21;

  logic [4:0] state;
  logic [4:0] state_next;

  assign busy = (state != S_LOAD);
  assign done = (state == S_OUT);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR0;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.full   = 1'b0;
    case (state)
      S_CLR0: begin
        cmd.op   = OP_CLR;
        cmd.full = 1'b1;
        if (st.clr_last) state_next = S_LOAD;
      end
      S_LOAD: begin
        if (start) begin
          cmd.op = OP_LOAD;
          if (last_entry) state_next = S_CHK_PRE;
        end
      end
      S_CHK_PRE: begin
        cmd.op     = OP_OVR;
        state_next = st.ovr ? S_CLR1 : S_CHK_RD;
      end
      S_CHK_RD: state_next = S_CHK_MK;
      S_CHK_MK: begin
        cmd.op     = OP_CHK_MK;
        state_next = S_CHK_TST;
      end
      S_CHK_TST: begin
        cmd.op     = OP_CHK_TST;
        state_next = (st.bad || st.last) ? S_CLR1 : S_CHK_RD;
      end
      S_CLR1: begin
        cmd.op = OP_CLR;
        if (st.clr_last) state_next = st.err_any ? S_OUT : S_WLK_RD;
      end
      S_WLK_RD: state_next = S_WLK_TST;
      S_WLK_TST: begin
        cmd.op     = OP_WLK_TST;
        state_next = st.new_cycle ? S_STEP_CHK : S_NEXT;
      end
      S_NEXT: begin
        cmd.op     = OP_NEXT;
        state_next = st.last ? S_CLR2 : S_WLK_RD;
      end
      S_STEP_CHK: begin
        if (st.step_go)  state_next = S_STEP_RD;
        else if (st.ovf) state_next = S_NEXT;
        else             state_next = S_DIV1_GO;
      end
      S_STEP_RD: begin
        cmd.op     = OP_STEP;
        state_next = S_STEP_UPD;
      end
      S_STEP_UPD: begin
        cmd.op     = OP_UPD;
        state_next = S_STEP_CHK;
      end
      S_DIV1_GO: begin
        cmd.op     = OP_DIV1;
        state_next = S_DIV1_WAIT;
      end
      S_DIV1_WAIT: begin
        if (st.div_done) begin
          cmd.op     = OP_GCD_INIT;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        cmd.op = OP_GCD;
        if (st.gcd_done) state_next = S_DIV2_GO;
      end
      S_DIV2_GO: begin
        cmd.op     = OP_DIV2;
        state_next = S_DIV2_WAIT;
      end
      S_DIV2_WAIT: begin
        if (st.div_done) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_MUL_CHK;
      end
      S_MUL_CHK: begin
        cmd.op     = OP_MUL_CHK;
        state_next = S_NEXT;
      end
      S_CLR2: begin
        cmd.op = OP_CLR;
        if (st.clr_last) state_next = S_OUT;
      end
      S_OUT: begin
        cmd.op     = OP_OUT;
        state_next = S_LOAD;
      end
      default: state_next = S_CLR0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/po_dpath.sv
// Datapath: image and mark memories, walk pointers, gcd and lcm arithmetic.
// Depends on po_pkg and po_div.
`timescale 1ns / 1ps
`default_nettype none
module po_dpath
  import po_pkg::*;
#(
  parameter int MAX_DEGREE = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  input  wire logic [IMG_W-1:0]  image_value,
  output sts_t                   st,
  output logic [ORD_W-1:0]       order_value,
  output logic                   order_overflow,
  output logic [STAT_W-1:0]      status_code
);

  localparam int AW = $clog2(MAX_DEGREE);
  localparam int CW = $clog2(MAX_DEGREE + 1);
  localparam int DW = CW + 1;
  localparam int XW = (CW > IMG_W) ? CW : IMG_W;
  localparam int PW = ORD_W + DW;

  logic [IMG_W-1:0] img_mem [MAX_DEGREE];
  logic             mark_mem [MAX_DEGREE];

  logic [CW-1:0]     count;
  logic              overrun;
  logic [STAT_W-1:0] err;
  logic [ORD_W-1:0]  acc;
  logic              ovf;
  logic [AW-1:0]     ptr;
  logic [AW-1:0]     cur;
  logic [DW-1:0]     len;
  logic [DW-1:0]     ga;
  logic [DW-1:0]     gb;
  logic [PW-1:0]     prod;
  logic [IMG_W-1:0]  img_q;
  logic              mark_q;

  logic [AW-1:0]     img_ra;
  logic [AW-1:0]     mark_ra;
  logic              mark_we;
  logic [AW-1:0]     mark_wa;
  logic              mark_wd;
  logic              img_we;
  logic              range_bad;
  logic [CW-1:0]     ptr_nx;
  logic [CW-1:0]     clr_lim;

  logic              div_start;
  logic [ORD_W-1:0]  div_dvd;
  logic [DW-1:0]     div_dsr;
  logic [ORD_W-1:0]  div_quo;
  logic [DW-1:0]     div_rem;
  logic              div_done;

  // Compares and status
  assign range_bad = XW'(img_q) >= XW'(count);
  assign ptr_nx    = CW'(ptr) + CW'(1);
  assign clr_lim   = cmd.full ? CW'(MAX_DEGREE) : count;

  assign st.ovr       = overrun;
  assign st.bad       = range_bad || mark_q;
  assign st.last      = (ptr_nx == count);
  assign st.clr_last  = (ptr_nx == clr_lim);
  assign st.new_cycle = !mark_q && (XW'(img_q) != XW'(ptr));
  assign st.step_go   = (cur != ptr) && (len <= DW'(count));
  assign st.div_done  = div_done;
  assign st.gcd_done  = (gb == '0);
  assign st.ovf       = ovf;
  assign st.err_any   = (err != ST_VALID);

  assign order_value    = acc;
  assign order_overflow = ovf;
  assign status_code    = err;

  // Memory port steering
  assign img_we  = (cmd.op == OP_LOAD) && (count != CW'(MAX_DEGREE));
  assign img_ra  = (cmd.op == OP_STEP) ? cur : ptr;
  assign mark_ra = (cmd.op == OP_CHK_MK) ? AW'(img_q) : ptr;

  always_comb begin
    mark_we = 1'b0;
    mark_wa = ptr;
    mark_wd = 1'b0;
    case (cmd.op)
      OP_CLR: mark_we = 1'b1;
      OP_CHK_TST: begin
        mark_we = !range_bad && !mark_q;
        mark_wa = AW'(img_q);
        mark_wd = 1'b1;
      end
      OP_STEP: begin
        mark_we = 1'b1;
        mark_wa = cur;
        mark_wd = 1'b1;
      end
      default: mark_we = 1'b0;
    endcase
  end

  // Image memory
  always_ff @(posedge clk) begin
    if (img_we) img_mem[count[AW-1:0]] <= image_value;
    img_q <= img_mem[img_ra];
  end

  // Seen / visited mark memory
  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_q <= mark_mem[mark_ra];
  end

  // Control and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      overrun <= 1'b0;
      err     <= ST_VALID;
      acc     <= ORD_W'(1);
      ovf     <= 1'b0;
      ptr     <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          if (count == CW'(MAX_DEGREE)) overrun <= 1'b1;
          else                          count   <= count + CW'(1);
        end
        OP_CLR: ptr <= st.clr_last ? '0 : ptr + AW'(1);
        OP_OVR: begin
          if (overrun) err <= ST_RANGE;
        end
        OP_CHK_TST: begin
          if (range_bad)   err <= ST_RANGE;
          else if (mark_q) err <= ST_DUP;
          ptr <= (st.bad || st.last) ? '0 : ptr + AW'(1);
        end
        OP_NEXT: ptr <= st.last ? '0 : ptr + AW'(1);
        OP_MUL_CHK: begin
          if (prod[PW-1:ORD_W] != '0) begin
            ovf <= 1'b1;
            acc <= '1;
          end else begin
            acc <= prod[ORD_W-1:0];
          end
        end
        OP_OUT: begin
          count   <= '0;
          overrun <= 1'b0;
          err     <= ST_VALID;
          acc     <= ORD_W'(1);
          ovf     <= 1'b0;
          ptr     <= '0;
        end
        default: ;
      endcase
    end
  end

  // Walk, gcd and product registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_WLK_TST: begin
        if (st.new_cycle) begin
          cur <= AW'(img_q);
          len <= DW'(1);
        end
      end
      OP_STEP: len <= len + DW'(1);
      OP_UPD:  cur <= AW'(img_q);
      OP_GCD_INIT: begin
        ga <= len;
        gb <= div_rem;
      end
      OP_GCD: begin
        if (gb != '0) begin
          if (ga >= gb) begin
            ga <= ga - gb;
          end else begin
            ga <= gb;
            gb <= ga;
          end
        end
      end
      OP_MUL: prod <= acc * div_quo[DW-1:0];
      default: ;
    endcase
  end

  // Shared divider: acc mod len, then len / gcd
  assign div_start = (cmd.op == OP_DIV1) || (cmd.op == OP_DIV2);
  assign div_dvd   = (cmd.op == OP_DIV1) ? acc : ORD_W'(len);
  assign div_dsr   = (cmd.op == OP_DIV1) ? len : ga;

  po_div #(
    .DW(DW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dsr),
    .quo     (div_quo),
    .rem     (div_rem),
    .done    (div_done)
  );

endmodule
`default_nettype wire

>>> rtl/permutation_order_core.sv
// Top level of the permutation order core: controller plus datapath.
// Depends on po_pkg, po_ctrl, po_dpath and the assertion macro header.
//
//   beat      strobe         payload
//   entry     start & !busy  image_value, last_entry
//   result    done           order_value, order_overflow, status_code
//
// Entries load one per cycle while busy is low. After the last entry the check
// runs CHK_RD, CHK_MK and CHK_TST for each entry, each mark clear sweeps the
// entries in turn, and the walk runs WLK_RD, WLK_TST and NEXT for each point
// plus STEP_CHK, STEP_RD and STEP_UPD for each step along a cycle. A non-fixed
// cycle adds two divider passes and a subtractive gcd; the bit-serial divider
// sets the pace. After reset a clear pass over the whole mark memory runs with
// busy high; the result strobe lasts one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
`include "permutation_order_core_assert.svh"
module permutation_order_core
  import po_pkg::*;
#(
  parameter int MAX_DEGREE = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [IMG_W-1:0]  image_value,
  input  wire logic              last_entry,
  output logic                   done,
  output logic [ORD_W-1:0]       order_value,
  output logic                   order_overflow,
  output logic [STAT_W-1:0]      status_code
);

  cmd_t cmd;
  sts_t st;
  logic fault_res;
  logic unit_order;

  // Sequencer
  po_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_entry(last_entry),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  // Memories and arithmetic
  po_dpath #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .image_value   (image_value),
    .st            (st),
    .order_value   (order_value),
    .order_overflow(order_overflow),
    .status_code   (status_code)
  );

  // Checks
  assign fault_res  = done && (status_code != ST_VALID);
  assign unit_order = (order_value == ORD_W'(1)) && !order_overflow;

  `PO_ASSERT_SAME(a_done_busy, done, busy, "result beat while idle")
  `PO_ASSERT_NEXT(a_done_once, done, !done && !busy, "result beat not single")
  `PO_ASSERT_SAME(a_fault_order, fault_res, unit_order, "faulty permutation with order")
  `PO_ASSERT_SAME(a_ovf_sat, done && order_overflow, &order_value, "overflow without saturation")

endmodule
`default_nettype wire

>>> verif/tb_permutation_order_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for permutation_order_core: loads permutations beat by beat,
// predicts order, overflow and status in SV, and checks every done strobe.
// Depends on po_pkg and the permutation_order_core RTL.
module tb_permutation_order_core;
  import po_pkg::*;

  localparam int DEG_MAX = 1024;

  typedef struct {
    logic [ORD_W-1:0]  ord;
    logic              ovf;
    logic [STAT_W-1:0] st;
  } order_res_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [IMG_W-1:0]  image_value = '0;
  logic              last_entry = 1'b0;
  wire               busy;
  wire               done;
  wire [ORD_W-1:0]   order_value;
  wire               order_overflow;
  wire [STAT_W-1:0]  status_code;

  // entries of the permutation being loaded, and results still owed
  int unsigned  loaded_img_q[$];
  bit           loaded_overrun;
  order_res_t   order_exp_q[$];
  bit           failed = 1'b0;
  bit           no_gaps = 1'b0;
  int           beats_sent = 0;

  permutation_order_core #(.MAX_DEGREE(DEG_MAX)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .image_value(image_value), .last_entry(last_entry),
    .done(done), .order_value(order_value),
    .order_overflow(order_overflow), .status_code(status_code)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Check in load order, then fold cycle lengths into an lcm
  function automatic order_res_t predict_order(int unsigned img[$], bit ovr);
    order_res_t r;
    bit seen[DEG_MAX];
    bit visited[DEG_MAX];
    int unsigned deg;
    int unsigned j;
    longint unsigned len;
    longint unsigned m;
    deg = img.size();
    r.ord = 64'd1;
    r.ovf = 1'b0;
    r.st = ST_VALID;
    if (ovr) begin
      r.st = ST_RANGE;
      return r;
    end
    for (int i = 0; i < deg; i++) begin
      if (img[i] >= deg) begin
        r.st = ST_RANGE;
        return r;
      end
      if (seen[img[i]]) begin
        r.st = ST_DUP;
        return r;
      end
      seen[img[i]] = 1'b1;
    end
    for (int i = 0; i < deg; i++) begin
      if (!visited[i] && img[i] != i) begin
        len = 1;
        j = img[i];
        while (j != i) begin
          visited[j] = 1'b1;
          len++;
          j = img[j];
        end
        if (!r.ovf) begin
          m = len / gcd64(r.ord, len);
          if (r.ord > 64'hFFFF_FFFF_FFFF_FFFF / m) begin
            r.ovf = 1'b1;
            r.ord = '1;
          end else begin
            r.ord = r.ord * m;
          end
        end
      end
    end
    return r;
  endfunction

  // Drive one entry beat; returns at the falling edge after acceptance
  task automatic send_entry(int unsigned v, bit last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    image_value = v[IMG_W-1:0];
    last_entry = last;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    beats_sent++;
    if (loaded_img_q.size() < DEG_MAX) loaded_img_q.push_back(v);
    else loaded_overrun = 1'b1;
    if (last) begin
      order_exp_q.push_back(predict_order(loaded_img_q, loaded_overrun));
      loaded_img_q.delete();
      loaded_overrun = 1'b0;
    end
    @(negedge clk);
  endtask

  task automatic send_perm(int unsigned p[$]);
    foreach (p[i]) send_entry(p[i], i == p.size() - 1);
  endtask

  function automatic void shuffled_perm(int n, ref int unsigned p[$]);
    int k;
    int unsigned t;
    p.delete();
    for (int i = 0; i < n; i++) p.push_back(i);
    for (int i = n - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = p[i]; p[i] = p[k]; p[k] = t;
    end
  endfunction

  // Result checker: done is a one-cycle strobe
  always @(posedge clk) begin
    order_res_t e;
    if (!rst && done) begin
      if (order_exp_q.size() == 0) begin
        $display("%0t: unexpected result order=%h ovf=%b st=%0d", $time,
                 order_value, order_overflow, status_code);
        failed = 1'b1;
      end else begin
        e = order_exp_q.pop_front();
        if (order_value !== e.ord) begin
          $display("%0t: order_value expected %h actual %h", $time, e.ord, order_value);
          failed = 1'b1;
        end
        if (order_overflow !== e.ovf) begin
          $display("%0t: order_overflow expected %b actual %b", $time, e.ovf,
                   order_overflow);
          failed = 1'b1;
        end
        if (status_code !== e.st) begin
          $display("%0t: status_code expected %0d actual %0d", $time, e.st, status_code);
          failed = 1'b1;
        end
      end
    end
  end

  // Fixed points, identity, swap, mixed cycles
  task automatic test_basic_orders();
    send_perm('{0});
    send_perm('{0, 1});
    send_perm('{1, 0});
    send_perm('{1, 2, 0, 4, 3});
    send_perm('{1, 2, 3, 0, 5, 4, 6});
  endtask

  // Out of range, duplicate, range fault ahead of a later duplicate, and duplicate ahead of a later range fault
  task automatic test_check_faults();
    send_perm('{1023, 0});
    send_perm('{0, 0, 1});
    send_perm('{0, 5, 0});
    send_perm('{1, 1, 7});
  endtask

  // Cycles of the primes up to 59 push the lcm past 64 bits; more cycles follow
  task automatic test_order_overflow();
    int unsigned lens[$] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
                             53, 59, 4, 9};
    int unsigned p[$];
    int unsigned base;
    base = 0;
    foreach (lens[k]) begin
      for (int i = 0; i < lens[k]; i++) p.push_back(base + (i + 1) % lens[k]);
      base += lens[k];
    end
    send_perm(p);
  endtask

  // Mostly well-formed permutations, some corrupted, a few large
  task automatic test_random_perms();
    int unsigned p[$];
    int n;
    int sel;
    int target;
    target = 900;
    while (beats_sent < target) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      n = (sel < 2) ? $urandom_range(100, 200) : $urandom_range(1, 24);
      shuffled_perm(n, p);
      if (sel >= 75 && sel < 85) p[$urandom_range(0, n - 1)] = $urandom_range(0, 1023);
      else if (sel >= 85 && n > 1) p[$urandom_range(1, n - 1)] = p[$urandom_range(0, n - 2)];
      send_perm(p);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_basic_orders();
    test_check_faults();
    test_order_overflow();
    test_random_perms();
    start = 1'b0;
    while (order_exp_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!failed) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
